// ----- hw/rtl/priority_event_queue_macros.svh -----
// ----------------------------------------------------------------------------
// Priority event queue assertion macros
// Shared property wrappers for the queue checker.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_EVENT_QUEUE_MACROS_SVH
`define PRIORITY_EVENT_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PEQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/peq_pkg.sv -----
// ----------------------------------------------------------------------------
// Priority event queue package
// Sizes, codes, slot record type and bitmap scan helpers.
// ----------------------------------------------------------------------------
package peq_pkg;

    localparam int SLOT_COUNT  = 16;
    localparam int PRIO_LEVELS = 32;
    localparam int ID_COUNT    = 48;

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int LVL_W  = $clog2(PRIO_LEVELS);

    localparam int ACTION_W  = 2;
    localparam int PRIO_W    = 5;
    localparam int ID_W      = 6;
    localparam int PAYLOAD_W = 32;
    localparam int LENGTH_W  = 16;
    localparam int STATUS_W  = 3;

    localparam int ID_EN_W    = 48;
    localparam int PRIO_EN_W  = 32;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_ID_OFF,
        ST_PRIO_OFF,
        ST_FULL,
        ST_EMPTY
    } t_status;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SUBMIT,
        ACT_DISPATCH,
        ACT_FLUSH,
        ACT_NONE
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ID_ENABLE,
        CFG_PRIO_ENABLE
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [PRIO_W-1:0]    prio;
        logic [ID_W-1:0]      id;
        logic [PAYLOAD_W-1:0] payload;
        logic [LENGTH_W-1:0]  length;
    } t_slot_rec;

    localparam int SLOT_DATA_W = $bits(t_slot_rec);

    function automatic logic [ID_EN_W-1:0] id_en_mask();
        logic [ID_EN_W-1:0] m;
        for (int i = 0; i < ID_EN_W; i++) begin
            m[i] = (i < ID_COUNT);
        end
        return m;
    endfunction

    function automatic logic [PRIO_EN_W-1:0] prio_en_mask();
        logic [PRIO_EN_W-1:0] m;
        for (int i = 0; i < PRIO_EN_W; i++) begin
            m[i] = (i < PRIO_LEVELS);
        end
        return m;
    endfunction

    localparam logic [ID_EN_W-1:0]   ID_EN_MASK   = id_en_mask();
    localparam logic [PRIO_EN_W-1:0] PRIO_EN_MASK = prio_en_mask();

    // Index of the lowest set bit; zero when the map is empty.
    function automatic logic [LVL_W-1:0] first_level(input logic [PRIO_LEVELS-1:0] map);
        logic [LVL_W-1:0] idx;
        idx = '0;
        for (int i = PRIO_LEVELS - 1; i >= 0; i--) begin
            if (map[i]) begin
                idx = LVL_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [SLOT_W-1:0] first_slot(input logic [SLOT_COUNT-1:0] map);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (map[i]) begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- hw/rtl/peq_ram.sv -----
// ----------------------------------------------------------------------------
// Priority event queue RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module peq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/priority_event_queue.sv -----
// ----------------------------------------------------------------------------
// Priority event queue
// Bitmap-priority ready queue: a pool of event slots linked into one FIFO
// per priority level, held in synchronous RAMs.
// ----------------------------------------------------------------------------
//
//   channel   handshake                   payload
//   -------   -------------------------   ------------------------------------
//   input     i_in_valid / o_in_ready     i_action i_prio i_id i_payload
//                                         i_length
//   result    o_out_valid / i_out_ready   o_status o_out_prio o_out_id
//                                         o_out_payload o_out_length
//   config    i_cfg_valid / o_cfg_ready   i_cfg_index i_cfg_data
//
// One beat in, one beat out. Submit, flush, refused and empty-dispatch beats
// go from S_IDLE straight to S_DONE; a served dispatch passes S_READ first:
// the head pointer must return before the record and link at that slot are read.
// One item is in flight at a time; the result register lets the next beat
// be accepted while a finished result still waits on i_out_ready.
// Reset is synchronous: every slot free, no level busy, all enables set, and
// both ready outputs low while it is held. RAM contents are not cleared,
// every entry is written before its read value is used.
// ----------------------------------------------------------------------------
module priority_event_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [peq_pkg::ACTION_W-1:0]        i_action,
    input  logic [peq_pkg::PRIO_W-1:0]          i_prio,
    input  logic [peq_pkg::ID_W-1:0]            i_id,
    input  logic [peq_pkg::PAYLOAD_W-1:0]       i_payload,
    input  logic [peq_pkg::LENGTH_W-1:0]        i_length,

    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [peq_pkg::STATUS_W-1:0]        o_status,
    output logic [peq_pkg::PRIO_W-1:0]          o_out_prio,
    output logic [peq_pkg::ID_W-1:0]            o_out_id,
    output logic [peq_pkg::PAYLOAD_W-1:0]       o_out_payload,
    output logic [peq_pkg::LENGTH_W-1:0]        o_out_length,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [peq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [peq_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    import peq_pkg::*;

    // Control state
    t_state                 r_state, n_state;
    logic [ID_EN_W-1:0]     r_id_en;
    logic [PRIO_EN_W-1:0]   r_prio_en;
    logic [PRIO_LEVELS-1:0] r_nonempty, n_nonempty;
    logic [SLOT_COUNT-1:0]  r_free, n_free;
    logic                   r_out_valid, n_out_valid;

    // Item held while in flight
    t_action                r_op;
    t_status                r_status;
    logic                   r_work;
    logic [LVL_W-1:0]       r_level;
    logic [SLOT_W-1:0]      r_slot;
    t_slot_rec              r_rec;

    // Result register
    t_status                r_out_status;
    t_slot_rec              r_out_rec;

    // Accept-cycle decode
    t_action                act;
    logic                   in_fire;
    logic                   id_ok;
    logic                   prio_ok;
    logic                   do_work;
    t_status                acc_status;
    logic [LVL_W-1:0]       lvl_sel;

    // Commit-cycle controls
    logic                   commit;
    logic                   sub_commit;
    logic                   dsp_commit;
    logic                   last_in_level;

    // RAM ports
    logic                   head_we, tail_we, link_we, slot_we;
    logic [SLOT_W-1:0]      head_wdata;
    logic [SLOT_W-1:0]      head_rdata, tail_rdata, link_rdata;
    logic [SLOT_DATA_W-1:0] slot_rdata;
    logic                   lvl_re, slot_re;

    // Hold both channels off while reset is applied.
    assign o_in_ready  = i_rst_n && (r_state == S_IDLE);
    assign o_cfg_ready = i_rst_n;
    assign in_fire     = i_in_valid && o_in_ready;
    assign act         = t_action'(i_action);

    // Id checked first, then the level, then the pool.
    assign id_ok   = (int'(i_id) < ID_COUNT) && r_id_en[i_id];
    assign prio_ok = (int'(i_prio) < PRIO_LEVELS) && r_prio_en[i_prio];

    always_comb begin
        acc_status = ST_OK;
        do_work    = 1'b0;
        case (act)
            ACT_SUBMIT: begin
                if (!id_ok) begin
                    acc_status = ST_ID_OFF;
                end else if (!prio_ok) begin
                    acc_status = ST_PRIO_OFF;
                end else if (r_free == '0) begin
                    acc_status = ST_FULL;
                end else begin
                    do_work = 1'b1;
                end
            end
            ACT_DISPATCH: begin
                if (r_nonempty == '0) begin
                    acc_status = ST_EMPTY;
                end else begin
                    do_work = 1'b1;
                end
            end
            default: begin
                acc_status = ST_OK;
            end
        endcase
    end

    // Dispatch serves the most urgent busy level; submit targets its own.
    assign lvl_sel = (act == ACT_DISPATCH) ? first_level(r_nonempty) : LVL_W'(i_prio);

    // Head and tail of the level are read in the accept cycle.
    assign lvl_re  = in_fire;
    // Slot record and link are read at the head slot in the following cycle, in S_READ.
    assign slot_re = (r_state == S_READ);

    assign commit        = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign sub_commit    = commit && r_work && (r_op == ACT_SUBMIT);
    assign dsp_commit    = commit && r_work && (r_op == ACT_DISPATCH);
    assign last_in_level = (tail_rdata == head_rdata);

    // Submit links the new slot behind the old tail, or starts the list.
    // Dispatch advances the head unless the popped slot was the tail.
    assign slot_we    = sub_commit;
    assign tail_we    = sub_commit;
    assign link_we    = sub_commit && r_nonempty[r_level];
    assign head_we    = (sub_commit && !r_nonempty[r_level])
                     || (dsp_commit && !last_in_level);
    assign head_wdata = sub_commit ? r_slot : link_rdata;

    always_comb begin
        n_state     = r_state;
        n_nonempty  = r_nonempty;
        n_free      = r_free;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = (act == ACT_DISPATCH && do_work) ? S_READ : S_DONE;
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (commit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    if (r_op == ACT_FLUSH) begin
                        n_free     = '1;
                        n_nonempty = '0;
                    end
                    if (sub_commit) begin
                        n_free[r_slot]      = 1'b0;
                        n_nonempty[r_level] = 1'b1;
                    end
                    if (dsp_commit) begin
                        n_free[head_rdata] = 1'b1;
                        if (last_in_level) begin
                            n_nonempty[r_level] = 1'b0;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nonempty  <= '0;
            r_free      <= '1;
            r_out_valid <= 1'b0;
            r_id_en     <= ID_EN_MASK;
            r_prio_en   <= PRIO_EN_MASK;
        end else begin
            r_state     <= n_state;
            r_nonempty  <= n_nonempty;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_ID_ENABLE: begin
                        r_id_en <= ID_EN_W'(i_cfg_data) & ID_EN_MASK;
                    end
                    CFG_PRIO_ENABLE: begin
                        r_prio_en <= PRIO_EN_W'(i_cfg_data) & PRIO_EN_MASK;
                    end
                    default: begin
                        r_id_en <= r_id_en;
                    end
                endcase
            end
        end
    end

    // Capture the item and its decode on accept; hold until commit.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op        <= act;
            r_status    <= acc_status;
            r_work      <= do_work;
            r_level     <= lvl_sel;
            r_slot      <= first_slot(r_free);
            r_rec.prio    <= i_prio;
            r_rec.id      <= i_id;
            r_rec.payload <= i_payload;
            r_rec.length  <= i_length;
        end
    end

    // Result register: only a served dispatch carries event fields.
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_status <= r_status;
            r_out_rec    <= dsp_commit ? t_slot_rec'(slot_rdata) : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_out_prio    = r_out_rec.prio;
    assign o_out_id      = r_out_rec.id;
    assign o_out_payload = r_out_rec.payload;
    assign o_out_length  = r_out_rec.length;

    // Per-level head pointers
    peq_ram #(.WIDTH(SLOT_W), .DEPTH(PRIO_LEVELS)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (r_level),
        .i_wdata (head_wdata),
        .i_re    (lvl_re),
        .i_raddr (lvl_sel),
        .o_rdata (head_rdata)
    );

    // Per-level tail pointers
    peq_ram #(.WIDTH(SLOT_W), .DEPTH(PRIO_LEVELS)) u_tail_ram (
        .i_clk   (i_clk),
        .i_we    (tail_we),
        .i_waddr (r_level),
        .i_wdata (r_slot),
        .i_re    (lvl_re),
        .i_raddr (lvl_sel),
        .o_rdata (tail_rdata)
    );

    // Per-slot next links
    peq_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (tail_rdata),
        .i_wdata (r_slot),
        .i_re    (slot_re),
        .i_raddr (head_rdata),
        .o_rdata (link_rdata)
    );

    // Per-slot event records
    peq_ram #(.WIDTH(SLOT_DATA_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (r_slot),
        .i_wdata (r_rec),
        .i_re    (slot_re),
        .i_raddr (head_rdata),
        .o_rdata (slot_rdata)
    );

endmodule

// ----- hw/rtl/peq_checker.sv -----
// ----------------------------------------------------------------------------
// Priority event queue checker
// Port-level properties of the queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "priority_event_queue_macros.svh"

module peq_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_ready,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic [peq_pkg::STATUS_W-1:0]        o_status,
    input  logic [peq_pkg::PRIO_W-1:0]          o_out_prio,
    input  logic [peq_pkg::ID_W-1:0]            o_out_id,
    input  logic [peq_pkg::PAYLOAD_W-1:0]       o_out_payload,
    input  logic [peq_pkg::LENGTH_W-1:0]        o_out_length
);

    import peq_pkg::*;

    // A stalled result beat holds.
    `PEQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_out_payload), "result beat changed while stalled")

    // A beat with a status other than OK carries zero event fields.
    `PEQ_ASSERT_IMPLY(a_refused_zero, i_clk, i_rst_n, o_out_valid && (o_status != ST_OK), o_out_prio == '0 && o_out_id == '0 && o_out_payload == '0 && o_out_length == '0, "refused beat carries event fields")

    // No input is accepted in the cycle after an accept.
    `PEQ_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input accepted on consecutive cycles")

endmodule

bind priority_event_queue peq_checker u_peq_checker (.*);
